FILE: design/bbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_pkg
// Types, register indexes and raster operation helpers for the 1bpp row blitter.
// ----------------------------------------------------------------------------
package bbr_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 16;
	localparam int REMAIN_W      = 17;

	localparam logic [CFG_INDEX_W-1:0] REG_TRANSFER_MODE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_OFFSET = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DEST_OFFSET   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_COUNT   = 2'd3;

	localparam logic [1:0] OP_COPY = 2'd0;
	localparam logic [1:0] OP_OR   = 2'd1;
	localparam logic [1:0] OP_XOR  = 2'd2;
	localparam logic [1:0] OP_BIC  = 2'd3;

	typedef struct packed {
		logic [7:0] source_byte;
		logic [7:0] old_dest_byte;
		logic       segment_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] new_dest_byte;
		logic       last_byte;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  transfer_mode;
		logic [2:0]  source_bit_offset;
		logic [2:0]  dest_bit_offset;
		logic [15:0] pixel_count;
	} cfg_t;

	typedef struct packed {
		logic [7:0]          held_source_byte;
		logic [REMAIN_W-1:0] pixels_remaining;
		logic                prefetch_pending;
		logic                first_pending;
	} seg_state_t;

	// Bit 2 of the mode inverts the source, bits 1:0 pick the operation.
	function automatic logic [7:0] raster_op(input logic [2:0] mode, input logic [7:0] s,
			input logic [7:0] d);
		logic [7:0] src;
		logic [7:0] r;
		src = mode[2] ? ~s : s;
		case (mode[1:0])
			OP_COPY: r = src;
			OP_OR:   r = d | src;
			OP_XOR:  r = d ^ src;
			default: r = d & ~src;
		endcase
		return r;
	endfunction

endpackage

FILE: design/bbr_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_step
// Per-item logic: segment bookkeeping, source realignment, masking and raster op.
// ----------------------------------------------------------------------------
module bbr_step (
	input  bbr_pkg::in_item_t   item,
	input  bbr_pkg::cfg_t       cfg,
	input  bbr_pkg::seg_state_t state,
	output bbr_pkg::seg_state_t state_next,
	output logic                result_valid,
	output bbr_pkg::out_item_t  result
);
	import bbr_pkg::*;

	seg_state_t  st;
	logic [2:0]  ls;
	logic [15:0] pair_shifted;
	logic [7:0]  aligned;
	logic [7:0]  mask;
	logic [7:0]  rop;
	logic        last;

	assign ls           = cfg.source_bit_offset - cfg.dest_bit_offset;
	assign pair_shifted = {st.held_source_byte, item.source_byte} << ls;
	assign aligned      = (ls == 3'd0) ? item.source_byte : pair_shifted[15:8];
	assign rop          = raster_op(cfg.transfer_mode, aligned, item.old_dest_byte);
	assign last         = (st.pixels_remaining <= REMAIN_W'(BITS_PER_BYTE));

	always_comb begin
		st = state;
		if (item.segment_start) begin
			st.held_source_byte = '0;
			st.first_pending    = 1'b1;
			st.pixels_remaining = (cfg.pixel_count == '0) ? '0
				: REMAIN_W'(cfg.dest_bit_offset) + REMAIN_W'(cfg.pixel_count);
			st.prefetch_pending = (st.pixels_remaining != '0)
				&& (cfg.source_bit_offset > cfg.dest_bit_offset);
		end

		mask = st.first_pending ? (8'hFF >> cfg.dest_bit_offset) : 8'hFF;
		// remaining is 0..8 here; the mask only matters for 1..8, where 8 - remaining fits in three bits
		if (last)
			mask = mask & (8'hFF << (3'd0 - st.pixels_remaining[2:0]));

		state_next   = st;
		result_valid = 1'b0;
		result.new_dest_byte = (item.old_dest_byte & ~mask) | (rop & mask);
		result.last_byte     = last;

		if (st.pixels_remaining != '0) begin
			state_next.held_source_byte = item.source_byte;
			if (st.prefetch_pending) begin
				state_next.prefetch_pending = 1'b0;
			end else begin
				result_valid              = 1'b1;
				state_next.first_pending  = 1'b0;
				state_next.pixels_remaining = last ? '0
					: st.pixels_remaining - REMAIN_W'(BITS_PER_BYTE);
			end
		end
	end

endmodule

FILE: design/mono_bitblt_row_segment.sv
`timescale 1ns / 1ps
// Output register: a result appears in the cycle after the item that yields it is accepted.
// Throughput: one item per cycle while the output is not stalled; the only loop is the segment state register.
// in_ready drops only while a result waits in the output register unclaimed.
// Reset: asynchronous, active low; clears segment state and the output valid,
// and loads the register defaults (copy mode, zero offsets, pixel count one).
// ----------------------------------------------------------------------------
// mono_bitblt_row_segment
// One-bit-per-pixel raster-op blitter for a single row segment.
// ----------------------------------------------------------------------------
module mono_bitblt_row_segment (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  bbr_pkg::in_item_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output bbr_pkg::out_item_t               out_data,
	input  logic                             cfg_we,
	input  logic [bbr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bbr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bbr_pkg::*;

	cfg_t       cfg_q;
	seg_state_t state_q;
	seg_state_t state_next;
	logic       result_valid;
	out_item_t  result;
	logic       out_valid_q;
	out_item_t  out_data_q;
	logic       accept;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	bbr_step u_step (
		.item         (in_data),
		.cfg          (cfg_q),
		.state        (state_q),
		.state_next   (state_next),
		.result_valid (result_valid),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.transfer_mode     <= '0;
			cfg_q.source_bit_offset <= '0;
			cfg_q.dest_bit_offset   <= '0;
			cfg_q.pixel_count       <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRANSFER_MODE: cfg_q.transfer_mode     <= cfg_data[2:0];
				REG_SOURCE_OFFSET: cfg_q.source_bit_offset <= cfg_data[2:0];
				REG_DEST_OFFSET:   cfg_q.dest_bit_offset   <= cfg_data[2:0];
				REG_PIXEL_COUNT:   cfg_q.pixel_count       <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (accept) begin
			state_q     <= state_next;
			out_valid_q <= result_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result until taken; the payload needs no reset
	always_ff @(posedge clk) begin
		if (accept && result_valid)
			out_data_q <= result;
	end

endmodule

FILE: bench/mono_bitblt_row_segment_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_bitblt_row_segment_tb
// Directed and random row segments through the 1bpp blitter. A software copy
// of the segment logic predicts each output byte; results are checked in order.
// ----------------------------------------------------------------------------
module mono_bitblt_row_segment_tb;
	import bbr_pkg::*;

	typedef enum logic [2:0] {
		MODE_COPY, MODE_OR, MODE_XOR, MODE_BIC,
		MODE_NOTCOPY, MODE_NOTOR, MODE_NOTXOR, MODE_NOTBIC
	} blit_mode_e;

	localparam int RANDOM_ITEMS = 1000;
	localparam int LONG_HOLD    = 200;
	localparam int SETTLE       = 4;
	localparam int MAX_REPORTS  = 10;
	localparam int HEAD_ITEMS   = 24;

	class row_blit_predictor;
		logic [2:0]          mode;
		logic [2:0]          src_off;
		logic [2:0]          dst_off;
		logic [15:0]         count;
		logic [7:0]          held;
		logic [REMAIN_W-1:0] remaining;
		bit                  prefetch;
		bit                  first;
		out_item_t           expected_bytes[$];
		int                  errors;

		function new();
			mode = MODE_COPY;
			src_off = '0;
			dst_off = '0;
			count = 16'd1;
			held = '0;
			remaining = '0;
			prefetch = 1'b0;
			first = 1'b0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_TRANSFER_MODE: mode = value[2:0];
				REG_SOURCE_OFFSET: src_off = value[2:0];
				REG_DEST_OFFSET:   dst_off = value[2:0];
				REG_PIXEL_COUNT:   count = value;
				default: ;
			endcase
		endfunction

		function void note_item(in_item_t it);
			logic [2:0]  shift;
			logic [15:0] pair;
			logic [7:0]  aligned;
			logic [7:0]  src;
			logic [7:0]  r;
			logic [7:0]  mask;
			out_item_t   want;
			if (it.segment_start) begin
				held = '0;
				first = 1'b1;
				remaining = (count == 0) ? '0 : {14'd0, dst_off} + {1'b0, count};
				prefetch = (remaining != 0) && (src_off > dst_off);
			end
			if (remaining == 0)
				return;
			// first item of a source-ahead segment only primes the held byte
			if (prefetch) begin
				held = it.source_byte;
				prefetch = 1'b0;
				return;
			end
			shift = src_off - dst_off;
			pair = {held, it.source_byte} << shift;
			aligned = (shift == 0) ? it.source_byte : pair[15:8];
			held = it.source_byte;
			mask = 8'hFF;
			if (first) begin
				mask = 8'hFF >> dst_off;
				first = 1'b0;
			end
			want.last_byte = 1'b0;
			if (remaining <= BITS_PER_BYTE) begin
				mask = mask & (8'hFF << (BITS_PER_BYTE - remaining));
				remaining = '0;
				want.last_byte = 1'b1;
			end else begin
				remaining = remaining - REMAIN_W'(BITS_PER_BYTE);
			end
			// upper mode bit inverts the source
			src = mode[2] ? ~aligned : aligned;
			case (mode[1:0])
				OP_COPY: r = src;
				OP_OR:   r = it.old_dest_byte | src;
				OP_XOR:  r = it.old_dest_byte ^ src;
				default: r = it.old_dest_byte & ~src;
			endcase
			want.new_dest_byte = (it.old_dest_byte & ~mask) | (r & mask);
			expected_bytes.push_back(want);
		endfunction

		function void check_byte(out_item_t got);
			out_item_t want;
			if (expected_bytes.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected output item: new_dest_byte %02h last_byte %0b",
						got.new_dest_byte, got.last_byte);
				return;
			end
			want = expected_bytes.pop_front();
			if (got.new_dest_byte !== want.new_dest_byte || got.last_byte !== want.last_byte) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("mismatch: new_dest_byte exp %02h got %02h, last_byte exp %0b got %0b",
						want.new_dest_byte, got.new_dest_byte, want.last_byte, got.last_byte);
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	in_item_t               in_data = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_item_t              out_data;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	bit                calm = 1'b0;
	bit                long_hold_req = 1'b0;
	row_blit_predictor blit_model;

	mono_bitblt_row_segment uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_item(input logic [7:0] s, input logic [7:0] d, input bit start);
		int       gap;
		in_item_t it;
		gap = calm ? 0 : $urandom_range(0, 3);
		it.source_byte = s;
		it.old_dest_byte = d;
		it.segment_start = start;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		blit_model.note_item(it);
	endtask

	task automatic send_random(input int n, input bit start_first);
		for (int i = 0; i < n; i++)
			send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				start_first && (i == 0));
	endtask

	// hold the input idle until every predicted byte is out, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (blit_model.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic program_regs(input logic [2:0] mode, input logic [2:0] soff,
			input logic [2:0] doff, input logic [15:0] count);
		logic [CFG_INDEX_W-1:0] idx [4];
		logic [CFG_DATA_W-1:0]  vals [4];
		idx = '{REG_TRANSFER_MODE, REG_SOURCE_OFFSET, REG_DEST_OFFSET, REG_PIXEL_COUNT};
		// junk in the unused upper data bits must be dropped
		vals[0] = {13'($urandom), mode};
		vals[1] = {13'($urandom), soff};
		vals[2] = {13'($urandom), doff};
		vals[3] = count;
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
			blit_model.set_reg(idx[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic int seg_items();
		int px;
		if (blit_model.count == 0)
			return 1;
		px = int'(blit_model.dst_off) + int'(blit_model.count);
		return (px + 7) / 8 + ((blit_model.src_off > blit_model.dst_off) ? 1 : 0);
	endfunction

	always @(posedge clk) begin
		if (out_valid && out_ready)
			blit_model.check_byte(out_data);
	end

	// receiver: random stall before each item, one long hold-off on request
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 3);
			if (long_hold_req) begin
				gap = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int          phase;
		int          rand_items;
		int          need;
		int          kind;
		int          pick;
		logic [15:0] count;
		phase = 0;
		rand_items = 0;
		blit_model = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: one pixel, copy, no offsets; then an item past the end
		send_item(8'hFF, 8'h00, 1'b1);
		send_item(8'h00, 8'hFF, 1'b0);
		drain();

		// source ahead of destination: prefetch item first
		program_regs(MODE_NOTBIC, 3'd7, 3'd0, 16'd16);
		send_item(8'hFF, 8'h5A, 1'b1);
		send_item(8'h00, 8'hFF, 1'b0);
		send_item(8'hFF, 8'h00, 1'b0);
		send_item(8'h81, 8'hAA, 1'b0);
		drain();

		program_regs(MODE_XOR, 3'd0, 3'd7, 16'd1);
		send_item(8'hFF, 8'hFF, 1'b1);
		drain();

		// empty segment
		program_regs(MODE_OR, 3'd4, 3'd4, 16'd0);
		send_item(8'hFF, 8'h00, 1'b1);
		send_item(8'hFF, 8'h00, 1'b0);
		drain();

		// mode changes mid-segment; the pixel count stays as sampled at start
		program_regs(MODE_COPY, 3'd2, 3'd5, 16'd40);
		send_random(3, 1'b1);
		drain();
		program_regs(MODE_NOTXOR, 3'd2, 3'd5, 16'd3);
		send_random(4, 1'b0);
		drain();

		// restart while a segment is still open
		program_regs(MODE_NOTOR, 3'd1, 3'd6, 16'd20);
		send_random(2, 1'b1);
		send_random(4, 1'b1);
		drain();

		while (rand_items < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 19);
			if (phase == 3)
				count = 16'd1500;
			else if (pick == 0)
				count = 16'd0;
			else if (pick < 3)
				count = 16'($urandom_range(100, 400));
			else
				count = 16'($urandom_range(1, 64));
			program_regs(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
				3'($urandom_range(0, 7)), count);
			need = seg_items();
			// stall the output long enough to back up the input
			if (phase == 3)
				long_hold_req = 1'b1;
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				send_random(need, 1'b1);
			end else if (kind == 7) begin
				send_random($urandom_range(1, need), 1'b1);
				send_random(need, 1'b1);
			end else if (kind == 8) begin
				send_random(need, 1'b1);
				send_random($urandom_range(1, 3), 1'b0);
			end else begin
				send_random($urandom_range(1, 3), 1'b0);
				send_random(need, 1'b1);
			end
			rand_items += need;
			drain();
			phase++;
		end

		// longest pixel count with a destination offset: run only the head of it
		calm = 1'b0;
		program_regs(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
			3'($urandom_range(1, 7)), 16'hFFFF);
		send_random(HEAD_ITEMS, 1'b1);
		drain();
		repeat (10) @(posedge clk);

		if (blit_model.errors == 0 && blit_model.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// timeout, several times the slowest legal run
	initial begin
		#(600_000 * 10);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
